>>> hw/rtl/sha1sbd_pkg.sv
// Shared types, constants and round functions for the SHA-1 block digest core.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package sha1sbd_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned HASH_N   = 5;
    localparam int unsigned SCHED_N  = 16;
    localparam int unsigned DIGEST_W = WORD_W * HASH_N;
    localparam int unsigned RND_W    = 7;

    localparam logic [RND_W-1:0] LAST_WORD  = 7'd15;
    localparam logic [RND_W-1:0] LAST_ROUND = 7'd79;

    // Round constants
    localparam logic [WORD_W-1:0] K_CH    = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_PAR_A = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_MAJ   = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_PAR_B = 32'hCA62C1D6;

    // Initial hash value
    localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
    localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
    localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

    // Round function group, one per twenty rounds
    typedef enum logic [1:0] {
        FN_CH    = 2'd0,
        FN_PAR_A = 2'd1,
        FN_MAJ   = 2'd2,
        FN_PAR_B = 2'd3
    } fsel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  round_en;   // run one round this cycle
        logic  init;       // start from the initial hash value
        logic  use_input;  // round word comes from the input item
        fsel_t fsel;       // round function group
        logic  capture;    // load the digest output register
    } cmd_t;

    function automatic logic [WORD_W-1:0] round_k(input fsel_t fsel);
        logic [WORD_W-1:0] k;
        case (fsel)
            FN_CH:    k = K_CH;
            FN_PAR_A: k = K_PAR_A;
            FN_MAJ:   k = K_MAJ;
            FN_PAR_B: k = K_PAR_B;
            default:  k = K_CH;
        endcase
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(input fsel_t fsel,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c,
                                                  input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] f;
        case (fsel)
            FN_CH:    f = (b & c) | (~b & d);
            FN_MAJ:   f = (b & c) | (b & d) | (c & d);
            FN_PAR_A: f = b ^ c ^ d;
            FN_PAR_B: f = b ^ c ^ d;
            default:  f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

>>> hw/rtl/sha1sbd_ctrl.sv
// Controller for the SHA-1 block digest core: word loading, round sequencing
// and the output valid flag. Depends on sha1sbd_pkg.
`timescale 1ns / 1ps

module sha1sbd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output sha1sbd_pkg::cmd_t  cmd
);
    import sha1sbd_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_ROUND = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             s_accept;
    logic             out_free;
    fsel_t            fsel;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // Pick the round function group from the round index
    always_comb begin
        if (rnd_reg inside {[7'd0:7'd19]}) begin
            fsel = FN_CH;
        end else if (rnd_reg inside {[7'd20:7'd39]}) begin
            fsel = FN_PAR_A;
        end else if (rnd_reg inside {[7'd40:7'd59]}) begin
            fsel = FN_MAJ;
        end else begin
            fsel = FN_PAR_B;
        end
    end

    // Drive datapath commands
    always_comb begin
        cmd.round_en  = s_accept || (state_reg == ST_ROUND);
        cmd.init      = (state_reg == ST_LOAD) && (rnd_reg == '0);
        cmd.use_input = (state_reg == ST_LOAD);
        cmd.fsel      = fsel;
        cmd.capture   = (state_reg == ST_FLUSH) && out_free;
    end

    // Advance through load, rounds and flush
    always_comb begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    rnd_next = rnd_reg + 7'd1;
                    if (rnd_reg == LAST_WORD) begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                if (rnd_reg == LAST_ROUND) begin
                    rnd_next   = '0;
                    state_next = ST_FLUSH;
                end else begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
                rnd_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            rnd_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rnd_reg      <= rnd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> hw/rtl/sha1sbd_datapath.sv
// Datapath for the SHA-1 block digest core: rolling message schedule,
// working registers, one round per cycle while cmd.round_en is set, and the
// digest output register. Depends on sha1sbd_pkg.
`timescale 1ns / 1ps

module sha1sbd_datapath (
    input  logic                                aclk,
    input  sha1sbd_pkg::cmd_t                   cmd,
    input  logic [sha1sbd_pkg::WORD_W-1:0]      word_in,
    output logic [sha1sbd_pkg::DIGEST_W-1:0]    digest
);
    import sha1sbd_pkg::*;

    // sched_reg[0] holds the newest schedule word
    logic [WORD_W-1:0] sched_reg [SCHED_N];
    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WORD_W-1:0] a_in, b_in, c_in, d_in, e_in;
    logic [WORD_W-1:0] w_mix, w_cur, sum;
    logic [DIGEST_W-1:0] digest_reg;

    // Select round inputs: initial value on the first word of a block
    always_comb begin
        a_in = cmd.init ? IV0 : a_reg;
        b_in = cmd.init ? IV1 : b_reg;
        c_in = cmd.init ? IV2 : c_reg;
        d_in = cmd.init ? IV3 : d_reg;
        e_in = cmd.init ? IV4 : e_reg;
    end

    // Expand the schedule from the t-3, t-8, t-14 and t-16 taps
    assign w_mix = sched_reg[2] ^ sched_reg[7] ^ sched_reg[13] ^ sched_reg[15];
    assign w_cur = cmd.use_input ? word_in : {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

    assign sum = {a_in[WORD_W-6:0], a_in[WORD_W-1:WORD_W-5]}
               + round_f(cmd.fsel, b_in, c_in, d_in)
               + e_in + round_k(cmd.fsel) + w_cur;

    // Run one round and shift the schedule
    always_ff @(posedge aclk) begin
        if (cmd.round_en) begin
            a_reg <= sum;
            b_reg <= a_in;
            c_reg <= {b_in[1:0], b_in[WORD_W-1:2]};
            d_reg <= c_in;
            e_reg <= d_in;
            sched_reg[0] <= w_cur;
            for (int i = 1; i < SCHED_N; i++) begin
                sched_reg[i] <= sched_reg[i-1];
            end
        end
    end

    // Hold the finished digest until taken
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            digest_reg <= {IV4 + e_reg, IV3 + d_reg, IV2 + c_reg,
                           IV1 + b_reg, IV0 + a_reg};
        end
    end

    assign digest = digest_reg;

endmodule

>>> hw/rtl/sha1_single_block_digest_core.sv
// SHA-1 single block digest core: sixteen words in, one five-word digest out.
// A block passes through the load of its sixteen words, rounds 16 to 79 on the
// one round unit, and a flush that shows the digest; no word of the next block is
// taken before that flush, and a waiting digest stalls flush.
// Reset: aresetn synchronous, active low; clears the controller and m_tvalid.
// Depends on sha1sbd_pkg, sha1sbd_ctrl and sha1sbd_datapath.
`timescale 1ns / 1ps

module sha1_single_block_digest_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sha1sbd_pkg::WORD_W-1:0]      s_tdata,   // [31:0] word
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sha1sbd_pkg::DIGEST_W-1:0]    m_tdata    // digest0..digest4, 32 bits each
);
    import sha1sbd_pkg::*;

    cmd_t cmd;

    sha1sbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sha1sbd_datapath u_datapath (
        .aclk    (aclk),
        .cmd     (cmd),
        .word_in (s_tdata),
        .digest  (m_tdata)
    );

endmodule

>>> hw/rtl/sha1sbd_checker.sv
// Port-level checker for the SHA-1 block digest core, bound to the top level.
// Depends on sha1_single_block_digest_core.
`timescale 1ns / 1ps

module sha1sbd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);

    logic [3:0] cnt_reg;
    logic       last_word;

    assign last_word = s_tvalid && s_tready && (cnt_reg == 4'd15);

    // Count accepted words within a block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (s_tvalid && s_tready) begin
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("digest dropped or changed while stalled");

    a_busy_after_block: assert property (@(posedge aclk) disable iff (!aresetn)
        last_word |=> !s_tready)
        else $error("input taken right after the last word of a block");

    a_busy_through_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        last_word |-> ##65 !s_tready)
        else $error("input taken before the rounds finished");

    a_digest_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready) && (cnt_reg == 4'd0))
        else $error("digest shown outside the end of a block");

endmodule

bind sha1_single_block_digest_core sha1sbd_checker u_sha1sbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sha1_single_block_digest_core_test.sv
// Self-checking testbench for the SHA-1 single block digest core.
// Streams 16-word blocks in, predicts each five-word digest and checks it.
// Depends on sha1sbd_pkg and sha1_single_block_digest_core.
`timescale 1ns / 1ps

module sha1_single_block_digest_core_test;

    import sha1sbd_pkg::*;

    typedef logic [WORD_W-1:0] word_t;

    // Digest item as carried on m_tdata, digest0 in the lowest bits
    typedef struct packed {
        word_t digest4;
        word_t digest3;
        word_t digest2;
        word_t digest1;
        word_t digest0;
    } digest_t;

    localparam int unsigned MAX_SHOWN   = 10;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RAND_BLOCKS = 115;

    // Block hash predictor and queue of digests still owed by the core
    class digest_scoreboard;
        logic [3:0]  word_idx;
        word_t       sched [SCHED_N];
        word_t       wv [HASH_N];
        digest_t     owed_digests [$];
        int unsigned failures;

        function new();
            word_idx = 4'd0;
            failures = 0;
        endfunction

        // One SHA-1 round on working values a..e
        function void run_round(int unsigned t, word_t w);
            word_t f;
            word_t k;
            word_t sum;
            fsel_t grp;
            if (t < 20)
                grp = FN_CH;
            else if (t < 40)
                grp = FN_PAR_A;
            else if (t < 60)
                grp = FN_MAJ;
            else
                grp = FN_PAR_B;
            case (grp)
                FN_CH: begin
                    f = (wv[1] & wv[2]) | (~wv[1] & wv[3]);
                    k = K_CH;
                end
                FN_PAR_A: begin
                    f = wv[1] ^ wv[2] ^ wv[3];
                    k = K_PAR_A;
                end
                FN_MAJ: begin
                    f = (wv[1] & wv[2]) | (wv[1] & wv[3]) | (wv[2] & wv[3]);
                    k = K_MAJ;
                end
                default: begin
                    f = wv[1] ^ wv[2] ^ wv[3];
                    k = K_PAR_B;
                end
            endcase
            sum   = {wv[0][26:0], wv[0][31:27]} + f + wv[4] + k + w;
            wv[4] = wv[3];
            wv[3] = wv[2];
            wv[2] = {wv[1][1:0], wv[1][31:2]};
            wv[1] = wv[0];
            wv[0] = sum;
        endfunction

        // Take one accepted word; on the last word of a block, queue its digest
        function void note_word(word_t w);
            word_t       x;
            digest_t     d;
            int unsigned t;
            if (word_idx == 4'd0)
                wv = '{IV0, IV1, IV2, IV3, IV4};
            sched[word_idx] = w;
            run_round(word_idx, w);
            if (word_idx != LAST_WORD[3:0]) begin
                word_idx = word_idx + 4'd1;
                return;
            end
            for (t = 16; t <= LAST_ROUND; t++) begin
                x = sched[(t - 3) & 15] ^ sched[(t - 8) & 15]
                  ^ sched[(t - 14) & 15] ^ sched[t & 15];
                x = {x[30:0], x[31]};
                sched[t & 15] = x;
                run_round(t, x);
            end
            d.digest0 = IV0 + wv[0];
            d.digest1 = IV1 + wv[1];
            d.digest2 = IV2 + wv[2];
            d.digest3 = IV3 + wv[3];
            d.digest4 = IV4 + wv[4];
            owed_digests.push_back(d);
            word_idx = 4'd0;
        endfunction

        function void flag_field(string name, word_t want, word_t got);
            failures++;
            if (failures <= MAX_SHOWN)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
        endfunction

        // Compare an accepted digest with the oldest one owed
        function void check_digest(digest_t got);
            digest_t want;
            if (owed_digests.size() == 0) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("%0t: digest %h arrived with none expected", $realtime, got);
                return;
            end
            want = owed_digests.pop_front();
            if (got.digest0 !== want.digest0) flag_field("digest0", want.digest0, got.digest0);
            if (got.digest1 !== want.digest1) flag_field("digest1", want.digest1, got.digest1);
            if (got.digest2 !== want.digest2) flag_field("digest2", want.digest2, got.digest2);
            if (got.digest3 !== want.digest3) flag_field("digest3", want.digest3, got.digest3);
            if (got.digest4 !== want.digest4) flag_field("digest4", want.digest4, got.digest4);
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata  = '0;       // [31:0] word
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DIGEST_W-1:0] m_tdata;             // digest0..digest4, 32 bits each

    digest_scoreboard sb = new();

    bit          idle_en      = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned gap_pct      = 0;
    int unsigned quiet_cycles = 0;

    sha1_single_block_digest_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Offer one word, with an optional idle burst first; hold it until taken
    task automatic send_word(input word_t w);
        if (idle_en && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
    endtask

    task automatic send_block(input word_t words [16]);
        for (int i = 0; i < 16; i++)
            send_word(words[i]);
    endtask

    // Random word biased toward the extremes and single-bit patterns
    function automatic word_t pick_word();
        word_t one_hot;
        one_hot = word_t'(1) << $urandom_range(0, WORD_W - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    // Sender: directed block, then random and message-shaped blocks
    initial begin
        word_t       blk [16];
        int unsigned n;
        int unsigned msg_len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes and alternating patterns, then the tail of a padded "abc"
        blk = '{32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h00000001,
                32'h7FFFFFFF, 32'hFFFFFFFE, 32'hAAAAAAAA, 32'h55555555,
                32'h61626380, 32'h00000000, 32'h00000000, 32'h00000000,
                32'h00000000, 32'h00000000, 32'h00000000, 32'h00000018};
        gap_pct = 0;
        send_block(blk);

        for (n = 0; n < RAND_BLOCKS; n++) begin
            if (n == 20)
                hold_request = 1'b1;
            if (n == RAND_BLOCKS - 15)
                idle_en = 1'b0;
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 40;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                // Padded message shape: data words, end marker, zeros, bit length
                msg_len = $urandom_range(0, 13);
                for (int i = 0; i < 16; i++) begin
                    if (i < msg_len)
                        blk[i] = $urandom;
                    else if (i == msg_len)
                        blk[i] = 32'h80000000;
                    else
                        blk[i] = '0;
                end
                blk[15] = word_t'(msg_len * 32);
            end else begin
                for (int i = 0; i < 16; i++)
                    blk[i] = pick_word();
            end
            send_block(blk);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for a stray late digest
        while (sb.owed_digests.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.failures == 0 && sb.owed_digests.size() == 0)
            $display("sha1_single_block_digest_core test passed");
        else
            $display("sha1_single_block_digest_core test failed");
        $finish;
    end

    // Receiver: check digests, stall in short bursts and hold off once for long
    initial begin
        int unsigned stall_left;
        bit          hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_digest(digest_t'(m_tdata));
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_request && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_tready   <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sha1_single_block_digest_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> files.f
hw/rtl/sha1sbd_pkg.sv
hw/rtl/sha1sbd_ctrl.sv
hw/rtl/sha1sbd_datapath.sv
hw/rtl/sha1_single_block_digest_core.sv
hw/rtl/sha1sbd_checker.sv
tb/sha1_single_block_digest_core_test.sv
